@@ rtl/uer_pkg.sv @@
package uer_pkg;

  // Defaults for the top-level parameters
  localparam int CountBitsDef   = 16;
  localparam int SensorCountDef = 4;

  // Fixed field widths
  localparam int ChanW     = 2;
  localparam int EchoW     = 4;
  localparam int TrigW     = 4;
  localparam int DistW     = 11;
  localparam int TrigTickW = 8;
  localparam int TimeoutW  = 16;
  localparam int PassW     = 4;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  // Distance = width / DistDiv + DistOffset
  localparam int DistDiv    = 60;
  localparam int RemW       = 6;
  localparam logic [RemW-1:0]  RemLast    = RemW'(DistDiv - 1);
  localparam logic [DistW-1:0] DistOffset = DistW'(4);

  // Register reset values
  localparam logic [TrigTickW-1:0] TrigTicksRst = TrigTickW'(15);
  localparam logic [TimeoutW-1:0]  TimeoutRst   = TimeoutW'(30000);
  localparam logic [PassW-1:0]     PassesRst    = '0;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTriggerTicks = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTimeoutTicks = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgAvgPasses    = CfgIdxW'(2);

  typedef enum logic [3:0] {
    PhIdle    = 4'b0001,
    PhTrigger = 4'b0010,
    PhWait    = 4'b0100,
    PhMeasure = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [TrigTickW-1:0] trigger_ticks;
    logic [TimeoutW-1:0]  timeout_ticks;
    logic [PassW-1:0]     average_passes;
  } cfg_t;

  // Packed so that trigger_lines lands in the lowest bits
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             done_res;
    logic             busy_res;
    logic [TrigW-1:0] trigger_lines;
  } result_t;

  localparam int ResW   = $bits(result_t);
  localparam int ResPad = ((ResW + 7) / 8) * 8 - ResW;

endpackage

@@ rtl/uer_ranger.sv @@
module uer_ranger
  import uer_pkg::*;
#(
  parameter int CountBits   = CountBitsDef,
  parameter int SensorCount = SensorCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             start_req_i,
  input  logic [ChanW-1:0] channel_i,
  input  logic [EchoW-1:0] echo_levels_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  localparam int CmpW = (CountBits > TimeoutW) ? CountBits : TimeoutW;
  localparam logic [CmpW-1:0] CountMax  = CmpW'({CountBits{1'b1}});
  localparam logic [3:0]      SensorLim = 4'(SensorCount);

  phase_e               phase_q, phase_d;
  logic [ChanW-1:0]     chan_q, chan_d;
  logic [CountBits-1:0] tick_q, tick_d;
  logic [CountBits-1:0] width_q, width_d;
  logic [DistW-1:0]     quot_q, quot_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic [DistW-1:0]     run_q, run_d;
  logic [PassW-1:0]     passes_q, passes_d;
  logic                 first_q, first_d;

  logic [CmpW-1:0]      lim;
  logic [CmpW-1:0]      timeout_ext;
  logic                 level;
  logic                 fin;
  logic                 done;
  logic [DistW-1:0]     fin_quot;
  logic [DistW-1:0]     dist_new;
  logic [DistW:0]       dist_sum;
  logic [CountBits-1:0] tick_inc;
  logic [CountBits-1:0] width_inc;

  // Width limit: timeout, never zero, capped by the counter range
  assign timeout_ext = CmpW'(cfg_i.timeout_ticks);
  always_comb begin
    if (cfg_i.timeout_ticks == '0) begin
      lim = CmpW'(1);
    end else if (timeout_ext > CountMax) begin
      lim = CountMax;
    end else begin
      lim = timeout_ext;
    end
  end

  assign level     = echo_levels_i[chan_q];
  assign tick_inc  = tick_q + CountBits'(1);
  assign width_inc = width_q + CountBits'(1);
  assign dist_new  = fin_quot + DistOffset;
  assign dist_sum  = {1'b0, run_q} + {1'b0, dist_new};

  always_comb begin
    phase_d  = phase_q;
    chan_d   = chan_q;
    tick_d   = tick_q;
    width_d  = width_q;
    quot_d   = quot_q;
    rem_d    = rem_q;
    run_d    = run_q;
    passes_d = passes_q;
    first_d  = first_q;
    fin      = 1'b0;
    fin_quot = '0;
    done     = 1'b0;

    if (step_i) begin
      unique case (phase_q)
        PhIdle: begin
          if (start_req_i && ({2'b00, channel_i} < SensorLim)) begin
            chan_d   = channel_i;
            passes_d = cfg_i.average_passes;
            first_d  = 1'b1;
            width_d  = '0;
            quot_d   = '0;
            rem_d    = '0;
            tick_d   = CountBits'(1);
            phase_d  = PhTrigger;
          end
        end
        PhTrigger: begin
          if (tick_q >= CountBits'(cfg_i.trigger_ticks)) begin
            tick_d  = '0;
            phase_d = PhWait;
          end else begin
            tick_d = tick_inc;
          end
        end
        PhWait: begin
          if (level) begin
            width_d = CountBits'(1);
            quot_d  = '0;
            rem_d   = RemW'(1);
            phase_d = PhMeasure;
            fin     = (lim == CmpW'(1));
          end else begin
            tick_d = tick_inc;
            if (CmpW'(tick_inc) >= lim) begin
              width_d = '0;
              quot_d  = '0;
              rem_d   = '0;
              fin     = 1'b1;
            end
          end
        end
        PhMeasure: begin
          if (!level || (CmpW'(width_q) >= lim)) begin
            fin      = 1'b1;
            fin_quot = quot_q;
          end else begin
            // Track width / 60 alongside the width itself
            width_d = width_inc;
            if (rem_q == RemLast) begin
              rem_d  = '0;
              quot_d = quot_q + DistW'(1);
            end else begin
              rem_d = rem_q + RemW'(1);
            end
            if (CmpW'(width_inc) >= lim) begin
              fin      = 1'b1;
              fin_quot = quot_d;
            end
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase

      if (fin) begin
        run_d   = first_q ? dist_new : dist_sum[DistW:1];
        first_d = 1'b0;
        if (passes_q != '0) begin
          passes_d = passes_q - PassW'(1);
          phase_d  = PhTrigger;
          tick_d   = CountBits'(1);
        end else begin
          phase_d = PhIdle;
          tick_d  = '0;
          done    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      chan_q   <= '0;
      tick_q   <= '0;
      width_q  <= '0;
      quot_q   <= '0;
      rem_q    <= '0;
      run_q    <= '0;
      passes_q <= '0;
      first_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      chan_q   <= chan_d;
      tick_q   <= tick_d;
      width_q  <= width_d;
      quot_q   <= quot_d;
      rem_q    <= rem_d;
      run_q    <= run_d;
      passes_q <= passes_d;
      first_q  <= first_d;
    end
  end

  always_comb begin
    res_o.trigger_lines = (phase_d == PhTrigger) ? (TrigW'(1) << chan_d) : '0;
    res_o.busy_res      = (phase_d != PhIdle);
    res_o.done_res      = done;
    res_o.distance      = run_d;
  end

endmodule

@@ rtl/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger for up to four sensors. Each item on the input
// stream is one timebase tick carrying a start request, a channel number
// and the current echo line levels; for every accepted item exactly one
// result item leaves on the output stream, showing the trigger drive, busy,
// done and the running distance as they stand after that tick. A start in
// idle pulses the chosen trigger line for trigger_ticks ticks, waits up to
// timeout_ticks for the echo to rise, then times its width (saturating at
// timeout_ticks, or at the counter range if that is smaller); the distance
// is width/60 + 4, and average_passes further passes are each folded in as
// (old + new) / 2. The quotient by 60 is kept as a running counter beside
// the width counter, so no divider sits in the path. Rate: one tick per
// clock, each result registered in the output stage. The only limit is
// the output stage: a result register backed by a one-entry skid register,
// so s_axis_tready falls only once both hold results the sink has not taken.
// Write configuration only while the block is idle; writes are always
// accepted and act from the next tick on.
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int CountBits   = CountBitsDef,
  parameter int SensorCount = SensorCountDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Tick stream in
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [0] start_req, [2:1] channel, [6:3] echo_levels, [7] zero
  input  logic [7:0]               s_axis_tdata,
  // Result stream out
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [3:0] trigger_lines, [4] busy_res, [5] done_res, [16:6] distance, rest zero
  output logic [ResW+ResPad-1:0]   m_axis_tdata,
  // Configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i
);

  cfg_t    cfg_q;
  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    in_take;
  logic    out_take;

  // Configuration registers: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks  <= TrigTicksRst;
      cfg_q.timeout_ticks  <= TimeoutRst;
      cfg_q.average_passes <= PassesRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTriggerTicks: cfg_q.trigger_ticks  <= cfg_data_i[TrigTickW-1:0];
        CfgTimeoutTicks: cfg_q.timeout_ticks  <= cfg_data_i[TimeoutW-1:0];
        CfgAvgPasses:    cfg_q.average_passes <= cfg_data_i[PassW-1:0];
        default: ;
      endcase
    end
  end

  // Accept a tick whenever the skid slot is free
  assign s_axis_tready = !skid_valid_q;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_take      = m_axis_tvalid && m_axis_tready;

  uer_ranger #(
    .CountBits  (CountBits),
    .SensorCount(SensorCount)
  ) u_ranger (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_take),
    .start_req_i  (s_axis_tdata[0]),
    .channel_i    (s_axis_tdata[2:1]),
    .echo_levels_i(s_axis_tdata[6:3]),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  // Result register plus skid: hold a new result in the skid slot while
  // the sink stalls, advance it once the result register drains.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_take) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{ResPad{1'b0}}, out_q};

  // The skid slot only fills behind a stalled result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds an item with no result in front");

  // A finished sequence reports idle on the same tick
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> !out_q.busy_res)
    else $error("done reported while still busy");

  // At most one sensor is triggered, and only during a sequence
  a_trigger_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($onehot0(out_q.trigger_lines)
                     && ((out_q.trigger_lines == '0) || out_q.busy_res)))
    else $error("bad trigger drive");

  // A stalled sink keeps the ready low once both slots are full
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("skid slot dropped while sink stalled");

endmodule

@@ tb/tb_ultrasonic_echo_ranger.sv @@
module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  // Longest run of cycles with no handshake on any channel before giving up
  localparam int StallLimit = 2000;
  // Ticks to send over the whole run; the random part fills up to this
  localparam int TotalTicks = 1050;
  // Index that maps to no register; a write there must change nothing
  localparam logic [CfgIdxW-1:0] CfgUnmapped = CfgIdxW'(3);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [0] start_req, [2:1] channel, [6:3] echo_levels, [7] zero
  logic [7:0]             s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [3:0] trigger_lines, [4] busy_res, [5] done_res, [16:6] distance, rest zero
  logic [ResW+ResPad-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i   = '0;
  logic [CfgDataW-1:0]    cfg_data_i    = '0;

  ultrasonic_echo_ranger uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Ranging predictor: its own copy of the registers and the sequence state,
  // starting from the reset values.
  // ---------------------------------------------------------------------------
  logic [TrigTickW-1:0] cfg_trig = TrigTicksRst;
  logic [TimeoutW-1:0]  cfg_tmo  = TimeoutRst;
  logic [PassW-1:0]     cfg_avg  = PassesRst;

  phase_e               rng_phase  = PhIdle;
  logic [ChanW-1:0]     rng_chan   = '0;
  logic [TimeoutW-1:0]  rng_ticks  = '0;
  logic [TimeoutW-1:0]  rng_width  = '0;
  logic [DistW-1:0]     rng_dist   = '0;
  logic [PassW-1:0]     rng_passes = '0;
  bit                   rng_first  = 1'b0;

  result_t pending_results[$];
  int      mismatch_cnt = 0;
  int      tick_total   = 0;
  bit      no_idle      = 1'b0;

  // Fold a finished pass into the running distance; 1 when the sequence ends.
  function automatic bit close_pass(input int unsigned width);
    int unsigned step_dist;
    step_dist = width / DistDiv + DistOffset;
    if (rng_first) begin
      // the first pass of a sequence replaces instead of averaging
      rng_dist  = DistW'(step_dist);
      rng_first = 1'b0;
    end else begin
      rng_dist = DistW'((rng_dist + step_dist) / 2);
    end
    if (rng_passes != 0) begin
      rng_passes--;
      rng_phase = PhTrigger;
      rng_ticks = 1;
      return 1'b0;
    end
    rng_phase = PhIdle;
    rng_ticks = 0;
    return 1'b1;
  endfunction

  // Advance the predicted sequence by one tick and build the expected result.
  function automatic result_t range_tick(input logic start, input logic [ChanW-1:0] ch,
                                         input logic [EchoW-1:0] echo);
    result_t     r;
    bit          done;
    bit          level;
    int unsigned lim;
    done  = 1'b0;
    level = echo[rng_chan];
    // zero timeout acts as one; 16 bits never exceed the counter range here
    lim   = (cfg_tmo == 0) ? 1 : cfg_tmo;
    case (rng_phase)
      PhIdle: begin
        if (start && ch < SensorCountDef) begin
          rng_chan   = ch;
          rng_passes = cfg_avg;
          rng_first  = 1'b1;
          rng_width  = 0;
          rng_ticks  = 1;
          rng_phase  = PhTrigger;
        end
      end
      PhTrigger: begin
        if (rng_ticks >= cfg_trig) begin
          rng_ticks = 0;
          rng_phase = PhWait;
        end else begin
          rng_ticks++;
        end
      end
      PhWait: begin
        if (level) begin
          rng_width = 1;
          rng_phase = PhMeasure;
          if (rng_width >= lim) done = close_pass(rng_width);
        end else begin
          rng_ticks++;
          // echo never rose: width counts as zero
          if (rng_ticks >= lim) begin
            rng_width = 0;
            done = close_pass(0);
          end
        end
      end
      default: begin
        if (!level || rng_width >= lim) begin
          done = close_pass(rng_width);
        end else begin
          rng_width++;
          if (rng_width >= lim) done = close_pass(rng_width);
        end
      end
    endcase
    r.trigger_lines = (rng_phase == PhTrigger) ? (TrigW'(1) << rng_chan) : '0;
    r.busy_res      = (rng_phase != PhIdle);
    r.done_res      = done;
    r.distance      = rng_dist;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Result sink: stall at random, hold ready high while no_idle is set.
  // ---------------------------------------------------------------------------
  int sink_hold = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      sink_hold     <= pick_gap() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  result_t seen_res;
  result_t want_res;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      seen_res = result_t'(m_axis_tdata[ResW-1:0]);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result, expected none, got %h", $time, seen_res);
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res.trigger_lines !== want_res.trigger_lines) begin
          mismatch_cnt++;
          $display("%0t: trigger_lines expected %b, got %b", $time,
                   want_res.trigger_lines, seen_res.trigger_lines);
        end
        if (seen_res.busy_res !== want_res.busy_res) begin
          mismatch_cnt++;
          $display("%0t: busy_res expected %b, got %b", $time,
                   want_res.busy_res, seen_res.busy_res);
        end
        if (seen_res.done_res !== want_res.done_res) begin
          mismatch_cnt++;
          $display("%0t: done_res expected %b, got %b", $time,
                   want_res.done_res, seen_res.done_res);
        end
        if (seen_res.distance !== want_res.distance) begin
          mismatch_cnt++;
          $display("%0t: distance expected %0d, got %0d", $time,
                   want_res.distance, seen_res.distance);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no handshake happens for too long.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one tick item, optionally after a gap; predict its result on accept.
  task automatic send_tick(input logic start, input logic [ChanW-1:0] ch,
                           input logic [EchoW-1:0] echo);
    int gap;
    gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, echo, ch, start};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(range_tick(start, ch, echo));
    tick_total++;
  endtask

  // Hold off the sender until every expected result has arrived.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Walk a running sequence to idle quickly: echo rises at once, falls at once.
  task automatic settle();
    while (rng_phase != PhIdle) begin
      send_tick(1'b0, ChanW'($urandom), {EchoW{rng_phase == PhWait}});
    end
  endtask

  // Bring the block to rest so that registers may be written.
  task automatic quiesce();
    settle();
    drain();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgTriggerTicks: cfg_trig = data[TrigTickW-1:0];
      CfgTimeoutTicks: cfg_tmo  = data[TimeoutW-1:0];
      CfgAvgPasses:    cfg_avg  = data[PassW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper bits of the narrow registers carry junk that must be dropped.
  task automatic set_config(input logic [TrigTickW-1:0] trig, input logic [TimeoutW-1:0] tmo,
                            input logic [PassW-1:0] avg);
    quiesce();
    write_reg(CfgTriggerTicks, {8'($urandom), trig});
    write_reg(CfgTimeoutTicks, tmo);
    write_reg(CfgAvgPasses, {12'($urandom), avg});
  endtask

  // Run one ranging sequence on channel ch. The echo rises dly ticks into the
  // wait and stays high wid_first ticks on the first pass, wid_rest on later
  // ones; with rnd set each pass draws its own values up to those bounds.
  // Other echo lines carry noise, and stray starts arrive while busy.
  task automatic range_seq(input logic [ChanW-1:0] ch, input int dly, input int wid_first,
                           input int wid_rest, input bit rnd);
    int               d;
    int               w;
    int               n;
    bit               first;
    bit               in_pass;
    logic [EchoW-1:0] e;
    settle();
    send_tick(1'b1, ch, EchoW'($urandom));
    d       = dly;
    w       = wid_first;
    n       = 0;
    first   = 1'b1;
    in_pass = 1'b0;
    while (rng_phase != PhIdle) begin
      e = EchoW'($urandom);
      case (rng_phase)
        PhTrigger: begin
          if (in_pass) begin
            first   = 1'b0;
            in_pass = 1'b0;
          end
          n = 0;
          d = rnd ? $urandom_range(0, dly) : dly;
          w = first ? wid_first : wid_rest;
          if (rnd) w = $urandom_range(1, w);
        end
        PhWait: begin
          in_pass = 1'b1;
          e[ch]   = (n >= d);
          n++;
        end
        default: begin
          e[ch] = (n < d + w);
          n++;
        end
      endcase
      send_tick($urandom_range(0, 7) == 0, ChanW'($urandom), e);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers, idle ticks, widths around one distance step.
  task automatic test_defaults();
    repeat (3) send_tick(1'b0, ChanW'($urandom), 4'hF);
    send_tick(1'b0, ChanW'($urandom), 4'h0);
    range_seq(0, 3, 61, 1, 1'b0);
    range_seq(3, 0, 59, 1, 1'b0);
    range_seq(1, 10, 60, 1, 1'b0);
  endtask

  // Zero and extreme register values, echo that never rises, averaging.
  task automatic test_register_extremes();
    // zero trigger and zero timeout both act as one
    set_config(0, 0, 0);
    range_seq(1, 0, 5, 1, 1'b0);
    range_seq(2, 3, 1, 1, 1'b0);
    set_config(255, 1, 0);
    range_seq(3, 0, 4, 1, 1'b0);
    set_config(1, 12, 2);
    range_seq(0, 20, 1, 1, 1'b0);
    set_config(1, 80, 1);
    // a write to the unmapped index must leave every register alone
    quiesce();
    write_reg(CfgUnmapped, 16'($urandom));
    range_seq(2, 4, 20, 200, 1'b0);
  endtask

  // Most passes with a short trigger, random echo timing per pass.
  task automatic test_max_passes();
    set_config(1, 8, 15);
    range_seq(2, 3, 10, 10, 1'b1);
  endtask

  // Echo held past the timeout: width saturates, then one short pass.
  task automatic test_long_echo();
    no_idle = 1'b1;
    set_config(1, 61, 1);
    range_seq(2, 0, 90, 1, 1'b0);
    no_idle = 1'b0;
  endtask

  // Mostly well-formed sequences under random settings, with noise bursts,
  // broken sequences and pauses for the results to drain.
  task automatic test_random();
    int lim;
    while (tick_total < TotalTicks) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        set_config(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 30))
                                               : 8'($urandom_range(0, 6)),
                   ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3))
                                               : 16'($urandom_range(20, 90)),
                   ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 4))
                                               : 4'($urandom_range(0, 2)));
      end
      lim = cfg_tmo;
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 12)) begin
          send_tick($urandom_range(0, 3) == 0, ChanW'($urandom), EchoW'($urandom));
        end
        1: drain();
        default: range_seq(ChanW'($urandom), $urandom_range(0, lim + 5),
                           $urandom_range(1, lim + 20), $urandom_range(1, lim + 20), 1'b1);
      endcase
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_register_extremes();
    test_max_passes();
    test_long_echo();
    test_random();

    // wait out the last results and the output stage behind them
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/uer_pkg.sv
rtl/uer_ranger.sv
rtl/ultrasonic_echo_ranger.sv
tb/tb_ultrasonic_echo_ranger.sv
